// ----- src/jvm_integer_arithmetic_unit_defines.svh -----
// assertion macros for the jvm integer arithmetic unit
// used by the top level only
`ifndef JVM_INTEGER_ARITHMETIC_UNIT_DEFINES_SVH
`define JVM_INTEGER_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define JIAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define JIAU_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define JIAU_ASSERT(label, clk, rst_n, prop)
`define JIAU_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- src/jiau_pkg.sv -----
// package for the jvm integer arithmetic unit
// op codes, widths and the cell payload struct
`default_nettype none
package jiau_pkg;
  localparam int unsigned XLEN = 64;
  localparam int unsigned NCELL = 64;
  localparam logic [3:0] OP_IADD = 4'd0;
  localparam logic [3:0] OP_LADD = 4'd1;
  localparam logic [3:0] OP_ISUB = 4'd2;
  localparam logic [3:0] OP_LSUB = 4'd3;
  localparam logic [3:0] OP_IMUL = 4'd4;
  localparam logic [3:0] OP_LMUL = 4'd5;
  localparam logic [3:0] OP_IDIV = 4'd6;
  localparam logic [3:0] OP_LDIV = 4'd7;
  localparam logic [3:0] OP_IREM = 4'd8;
  localparam logic [3:0] OP_LREM = 4'd9;
  localparam logic [3:0] OP_INEG = 4'd10;
  localparam logic [3:0] OP_LNEG = 4'd11;

  typedef struct packed {
    logic            vld;
    logic            is_int;
    logic            is_div;
    logic            is_rem;
    logic            dz;
    logic            neg_q;
    logic            neg_r;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dvsr;
    logic [XLEN-1:0] res;
  } cell_t;
endpackage
`default_nettype wire

// ----- src/jiau_if.sv -----
// valid/ready channel interfaces for the jvm integer arithmetic unit
// depends on jiau_pkg
`default_nettype none
interface jiau_in_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               func;
  logic [jiau_pkg::XLEN-1:0] operand_a;
  logic [jiau_pkg::XLEN-1:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface jiau_out_if;
  logic                     valid;
  logic                     ready;
  logic [jiau_pkg::XLEN-1:0] result;
  logic                     divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink (input valid, result, divide_by_zero, output ready);
endinterface
`default_nettype wire

// ----- src/jiau_front.sv -----
// decode cell: add, sub, neg and low multiply, divide setup
// depends on jiau_pkg
`default_nettype none
module jiau_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      vld_in,
  input  wire logic [3:0]                func,
  input  wire logic [jiau_pkg::XLEN-1:0] operand_a,
  input  wire logic [jiau_pkg::XLEN-1:0] operand_b,
  output jiau_pkg::cell_t                cell_o
);
  logic [63:0] a, b, ma, mb, r;
  logic        is_int;
  logic [63:0] p_ll, p_lh, p_hl;
  jiau_pkg::cell_t c_nxt, c_r;
  logic        mul_r;

  always_comb begin
    is_int = ~func[0];
    a = is_int ? {{32{operand_a[31]}}, operand_a[31:0]} : operand_a;
    b = is_int ? {{32{operand_b[31]}}, operand_b[31:0]} : operand_b;
    ma = a[63] ? 64'd0 - a : a;
    mb = b[63] ? 64'd0 - b : b;
    p_ll = 64'(a[31:0]) * 64'(b[31:0]);
    p_lh = 64'(a[31:0]) * 64'(b[63:32]);
    p_hl = 64'(a[63:32]) * 64'(b[31:0]);
    r = '0;
    c_nxt = '0;
    c_nxt.vld = vld_in;
    c_nxt.is_int = is_int;
    unique case (func)
      jiau_pkg::OP_IADD, jiau_pkg::OP_LADD: r = a + b;
      jiau_pkg::OP_ISUB, jiau_pkg::OP_LSUB: r = a - b;
      jiau_pkg::OP_INEG, jiau_pkg::OP_LNEG: r = 64'd0 - a;
      jiau_pkg::OP_IMUL, jiau_pkg::OP_LMUL: begin
        c_nxt.quo = p_ll;
        c_nxt.rem = p_lh;
        c_nxt.dvsr = p_hl;
      end
      jiau_pkg::OP_IDIV, jiau_pkg::OP_LDIV, jiau_pkg::OP_IREM, jiau_pkg::OP_LREM: begin
        c_nxt.is_div = 1'b1;
        c_nxt.is_rem = func[3];
        c_nxt.dz = (b == 64'd0);
        c_nxt.neg_q = a[63] ^ b[63];
        c_nxt.neg_r = a[63];
        c_nxt.quo = ma;
        c_nxt.dvsr = mb;
      end
      default: c_nxt.is_int = 1'b0;
    endcase
    c_nxt.res = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
    if (en) begin
      mul_r <= (func == jiau_pkg::OP_IMUL) || (func == jiau_pkg::OP_LMUL);
    end
  end

  always_comb begin
    cell_o = c_r;
    if (mul_r) begin
      cell_o.res = c_r.quo + {c_r.rem[31:0] + c_r.dvsr[31:0], 32'd0};
      cell_o.quo = '0;
      cell_o.rem = '0;
      cell_o.dvsr = '0;
    end
  end
endmodule
`default_nettype wire

// ----- src/jiau_cell.sv -----
// one restoring divide step cell, passes other ops through
// depends on jiau_pkg
`default_nettype none
module jiau_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire jiau_pkg::cell_t cell_i,
  output jiau_pkg::cell_t      cell_o
);
  jiau_pkg::cell_t c_nxt, c_r;
  logic [64:0] sh, df;

  always_comb begin
    c_nxt = cell_i;
    sh = {cell_i.rem, cell_i.quo[63]};
    df = sh - {1'b0, cell_i.dvsr};
    if (cell_i.is_div) begin
      if (!df[64]) begin
        c_nxt.rem = df[63:0];
      end else begin
        c_nxt.rem = sh[63:0];
      end
      c_nxt.quo = {cell_i.quo[62:0], ~df[64]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  assign cell_o = c_r;
endmodule
`default_nettype wire

// ----- src/jvm_integer_arithmetic_unit.sv -----
// pipeline: decode, 64 divide cells and output register between input transfer and result
// throughput: one item per cycle for every op while the chain advances; all items travel the cell chain
// the chain advances whenever the output register is empty or being taken
// synchronous active-low reset clears all valid bits; payloads are not reset
// depends on jiau_pkg, jiau_if, jiau_front, jiau_cell and the defines header
`include "jvm_integer_arithmetic_unit_defines.svh"
`default_nettype none
module jvm_integer_arithmetic_unit (
  input wire logic  clk,
  input wire logic  rst_n,
  jiau_in_if.sink   in_ch,
  jiau_out_if.source out_ch
);
  localparam int unsigned N = jiau_pkg::NCELL;
  jiau_pkg::cell_t chain [N+1];
  logic en;
  logic out_vld_r;
  logic [63:0] res_nxt;
  logic [63:0] out_res_r;
  logic out_dz_r;

  assign en = ~out_vld_r | out_ch.ready;
  assign in_ch.ready = en;

  jiau_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_ch.valid),
    .func(in_ch.func), .operand_a(in_ch.operand_a), .operand_b(in_ch.operand_b),
    .cell_o(chain[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    jiau_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en), .cell_i(chain[g]),
                      .cell_o(chain[g+1]));
  end

  always_comb begin
    res_nxt = chain[N].res;
    if (chain[N].is_div) begin
      if (chain[N].dz) begin
        res_nxt = '0;
      end else if (chain[N].is_rem) begin
        res_nxt = chain[N].neg_r ? 64'd0 - chain[N].rem : chain[N].rem;
      end else begin
        res_nxt = chain[N].neg_q ? 64'd0 - chain[N].quo : chain[N].quo;
      end
    end
    if (chain[N].is_int) begin
      res_nxt = {{32{res_nxt[31]}}, res_nxt[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= chain[N].vld;
    end
    if (en) begin
      out_res_r <= res_nxt;
      out_dz_r <= chain[N].is_div & chain[N].dz;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.result = out_res_r;
  assign out_ch.divide_by_zero = out_dz_r;

  `JIAU_ASSERT(a_stall_hold, clk, rst_n, out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_res_r))
  `JIAU_ASSERT(a_ready_free, clk, rst_n, !out_vld_r |-> in_ch.ready)
  `JIAU_ASSERT(a_dz_zero, clk, rst_n, out_vld_r && out_dz_r |-> out_res_r == 64'd0)
  `JIAU_ASSERT_RST(a_reset, clk, !rst_n |=> !out_vld_r)
endmodule
`default_nettype wire
